// ===== rtl/bnfpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bnfpa_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_MARK   = 2'd0,
        CMD_TEST   = 2'd1,
        CMD_APPEND = 2'd2,
        CMD_ALLOC  = 2'd3
    } cmd_t;

    // Result status codes carried in m_tuser
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_FAIL   = 2'd1;
    localparam logic [1:0] STS_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] CFG_WINDOW_BASE  = 1'b0;
    localparam logic [0:0] CFG_WINDOW_PAGES = 1'b1;

    localparam logic [16:0] WINDOW_PAGES_RST = 17'h10000;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;        // latch an input word
        logic clr_step;    // write one zero word of the clearing pass
        logic rd_page;     // read the bitmap word of the latched page
        logic mark_wr;     // write back the word with the page bit set
        logic test_res;    // capture test result
        logic oow_res;     // page outside window result
        logic app_do;      // append range and capture result
        logic alloc_init;  // load scan position from cursor
        logic wrap;        // start second pass from the top
        logic fail_res;    // no free page: result and cursor to top
        logic next_range;  // advance to next range
        logic load_range;  // load clipped bounds of current range
        logic rd_scan;     // read bitmap word at scan position
        logic found_wr;    // set found bit, move cursor, capture result
        logic next_word;   // advance scan to next bitmap word
        logic out_load;    // move result into output register
    } ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic clr_done;
        logic in_win;
        logic r_end;
        logic pass2;
        logic rng_empty;
        logic found;
        logic last_word;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/bitmap_next_fit_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-fit page allocator over a used-page bitmap and a table of up to
// MAX_RANGES page ranges. After reset the bitmap is cleared one 64-page word
// per cycle, during which no word is accepted (config writes are taken).
// Mark and test read the bitmap word of the page and, for mark, write it back
// with the page bit set; append adds a range to the table. Allocate walks the
// ranges from the cursor, reading and scanning one bitmap word at a time, and
// wraps once to the first range; the worst case visits every range twice.
// One word is worked at a time; a finished result waits in the output
// register while the next word is accepted.
module bitmap_next_fit_page_allocator
#(
    parameter int BITMAP_PAGES = 65536,
    parameter int MAX_RANGES   = 16
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Config write port
    input  wire logic                             cfg_we,
    input  wire logic [0:0]                       cfg_addr,
    input  wire logic [31:0]                      cfg_wdata,
    // Command stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bnfpa_pkg::S_TDATA_W-1:0]  s_tdata,   // page[31:0], range_end[63:32]
    input  wire logic [1:0]                       s_tuser,   // cmd[1:0]
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bnfpa_pkg::M_TDATA_W-1:0]       m_tdata,   // page_out[31:0], is_used[32]
    output logic [1:0]                            m_tuser    // status[1:0]
);

    bnfpa_pkg::ctl_t ctl;
    bnfpa_pkg::sts_t sts;

    bnfpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    bnfpa_datapath
    #(
        .BITMAP_PAGES (BITMAP_PAGES),
        .MAX_RANGES   (MAX_RANGES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== rtl/bnfpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bnfpa_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire bnfpa_pkg::sts_t   sts,
    output bnfpa_pkg::ctl_t        ctl
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DEC    = 8'b0000_0100,
        S_RMW    = 8'b0000_1000,
        S_RSETUP = 8'b0001_0000,
        S_RD     = 8'b0010_0000,
        S_SCAN   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.take   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (sts.cmd)
                    bnfpa_pkg::CMD_MARK, bnfpa_pkg::CMD_TEST:
                    begin
                        if (sts.in_win)
                        begin
                            ctl.rd_page = 1'b1;
                            state_next  = S_RMW;
                        end
                        else
                        begin
                            ctl.oow_res = 1'b1;
                            state_next  = S_OUT;
                        end
                    end
                    bnfpa_pkg::CMD_APPEND:
                    begin
                        ctl.app_do = 1'b1;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        ctl.alloc_init = 1'b1;
                        state_next     = S_RSETUP;
                    end
                endcase
            end
            S_RMW:
            begin
                if (sts.cmd == bnfpa_pkg::CMD_MARK)
                begin
                    ctl.mark_wr = 1'b1;
                end
                else
                begin
                    ctl.test_res = 1'b1;
                end
                state_next = S_OUT;
            end
            S_RSETUP:
            begin
                if (sts.r_end)
                begin
                    if (!sts.pass2)
                    begin
                        ctl.wrap = 1'b1;
                    end
                    else
                    begin
                        ctl.fail_res = 1'b1;
                        state_next   = S_OUT;
                    end
                end
                else if (sts.rng_empty)
                begin
                    ctl.next_range = 1'b1;
                end
                else
                begin
                    ctl.load_range = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                ctl.rd_scan = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.found)
                begin
                    ctl.found_wr = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.last_word)
                begin
                    ctl.next_range = 1'b1;
                    state_next     = S_RSETUP;
                end
                else
                begin
                    ctl.next_word = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bnfpa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bnfpa_datapath
#(
    parameter int BITMAP_PAGES = 65536,
    parameter int MAX_RANGES   = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [0:0]                        cfg_addr,
    input  wire logic [31:0]                       cfg_wdata,
    input  wire logic [bnfpa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [bnfpa_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic [1:0]                             m_tuser,
    input  wire bnfpa_pkg::ctl_t                   ctl,
    output bnfpa_pkg::sts_t                        sts
);

    localparam int WORDS = (BITMAP_PAGES + 63) / 64;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OW    = $clog2(BITMAP_PAGES);
    localparam int RIW   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int RCW   = $clog2(MAX_RANGES + 1);
    localparam logic [32:0]    BP33      = 33'(BITMAP_PAGES);
    localparam logic [AW-1:0]  LAST_WORD = AW'(WORDS - 1);
    localparam logic [RCW-1:0] MAX_CNT   = RCW'(MAX_RANGES);
    localparam logic [OW-1:0]  BIT_MASK  = OW'(63);

    // Configuration and derived window bounds
    logic [31:0] base_reg;
    logic [16:0] npages_reg;
    logic [32:0] ws_reg;
    logic [32:0] whi_reg;
    logic        wzero_reg;
    logic [32:0] ws_next;

    // Latched input word
    bnfpa_pkg::cmd_t cmd_reg;
    logic [31:0]     page_reg;
    logic [31:0]     rend_reg;

    // Bitmap memory
    logic [63:0]   bitmap_mem [WORDS];
    logic [63:0]   rdata_reg;
    logic [AW-1:0] clr_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [63:0]   mem_wdata;

    // Range table
    logic [31:0]    low_mem  [MAX_RANGES];
    logic [31:0]    high_mem [MAX_RANGES];
    logic [RCW-1:0] count_reg;
    logic           app_ok;

    // Scan and cursor state
    logic [RCW-1:0] r_reg;
    logic [31:0]    start_reg;
    logic           pass_reg;
    logic [RCW-1:0] cur_r_reg;
    logic [31:0]    cur_p_reg;
    logic [OW-1:0]  offq_reg;
    logic [OW-1:0]  offb_reg;

    // Result holding register
    logic [1:0]  res_status_reg;
    logic [31:0] res_page_reg;
    logic        res_used_reg;

    // Output register
    logic                            m_tvalid_reg;
    logic [bnfpa_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    // Combinational helpers
    logic [32:0]    offp33;
    logic [OW-1:0]  offp;
    logic           in_win;
    logic [RIW-1:0] rix;
    logic [31:0]    rlow;
    logic [31:0]    rhigh;
    logic [31:0]    lo_a;
    logic [31:0]    lo_b;
    logic [32:0]    hi33;
    logic           rng_empty;
    logic [OW-1:0]  offa;
    logic [OW-1:0]  offb_n;
    logic [OW-1:0]  wq;
    logic [OW-1:0]  wb;
    logic           last_word;
    logic [5:0]     lo_j;
    logic [5:0]     hi_j;
    logic [5:0]     fj;
    logic           found;
    logic [OW-1:0]  f_off;
    logic [31:0]    p_found;
    logic           p_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            npages_reg <= bnfpa_pkg::WINDOW_PAGES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bnfpa_pkg::CFG_WINDOW_BASE:  base_reg   <= cfg_wdata;
                bnfpa_pkg::CFG_WINDOW_PAGES: npages_reg <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // Window size clamped to the bitmap, and last covered page
    assign ws_next = ({16'b0, npages_reg} > BP33) ? BP33 : {16'b0, npages_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg    <= '0;
            whi_reg   <= '0;
            wzero_reg <= 1'b1;
        end
        else
        begin
            ws_reg    <= ws_next;
            whi_reg   <= {1'b0, base_reg} + ws_next - 33'd1;
            wzero_reg <= (ws_next == '0);
        end
    end

    // Input word latch
    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            cmd_reg  <= bnfpa_pkg::cmd_t'(s_tuser);
            page_reg <= s_tdata[31:0];
            rend_reg <= s_tdata[63:32];
        end
    end

    // Window check of the latched page
    assign offp33 = {1'b0, page_reg} - {1'b0, base_reg};
    assign offp   = offp33[OW-1:0];
    assign in_win = (page_reg >= base_reg) && (offp33 < ws_reg);

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clr_step)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    // Bitmap port selection
    always_comb
    begin
        mem_re    = ctl.rd_page | ctl.rd_scan;
        mem_raddr = ctl.rd_page ? AW'(offp >> 6) : AW'(offq_reg >> 6);
        mem_we    = ctl.clr_step | ctl.mark_wr | ctl.found_wr;
        if (ctl.clr_step)
        begin
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (ctl.mark_wr)
        begin
            mem_waddr = AW'(offp >> 6);
            mem_wdata = rdata_reg | (64'd1 << offp[5:0]);
        end
        else
        begin
            mem_waddr = AW'(offq_reg >> 6);
            mem_wdata = rdata_reg | (64'd1 << fj);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= bitmap_mem[mem_raddr];
        end
    end

    // Range table append
    assign app_ok = (rend_reg != '0) && (count_reg < MAX_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.app_do && app_ok)
        begin
            count_reg <= count_reg + RCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.app_do && app_ok)
        begin
            low_mem[count_reg[RIW-1:0]]  <= page_reg;
            high_mem[count_reg[RIW-1:0]] <= rend_reg;
        end
    end

    // Current range clipped to the window and the scan start
    assign rix       = r_reg[RIW-1:0];
    assign rlow      = low_mem[rix];
    assign rhigh     = high_mem[rix];
    assign lo_a      = (start_reg > rlow) ? start_reg : rlow;
    assign lo_b      = (lo_a > base_reg) ? lo_a : base_reg;
    assign hi33      = ({1'b0, rhigh} < whi_reg) ? {1'b0, rhigh} : whi_reg;
    assign rng_empty = wzero_reg || ({1'b0, lo_b} > hi33);
    assign offa      = OW'(lo_b - base_reg);
    assign offb_n    = OW'(hi33 - {1'b0, base_reg});

    // First clear bit of the word between scan position and range end
    assign wq        = offq_reg >> 6;
    assign wb        = offb_reg >> 6;
    assign last_word = (wq == wb);
    assign lo_j      = offq_reg[5:0];
    assign hi_j      = last_word ? offb_reg[5:0] : 6'd63;

    always_comb
    begin
        fj    = '0;
        found = 1'b0;
        for (int j = 63; j >= 0; j--)
        begin
            if (!rdata_reg[j] && (6'(j) >= lo_j) && (6'(j) <= hi_j))
            begin
                fj    = 6'(j);
                found = 1'b1;
            end
        end
    end

    assign f_off   = (offq_reg & ~BIT_MASK) | OW'(fj);
    assign p_found = base_reg + 32'(f_off);
    assign p_last  = (p_found >= rhigh);

    // Scan position and cursor; a scan always resumes at the cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg     <= '0;
            start_reg <= '0;
            pass_reg  <= 1'b0;
            cur_r_reg <= '0;
            cur_p_reg <= '0;
        end
        else
        begin
            if (ctl.alloc_init)
            begin
                pass_reg  <= 1'b0;
                r_reg     <= cur_r_reg;
                start_reg <= cur_p_reg;
            end
            if (ctl.wrap)
            begin
                r_reg     <= '0;
                start_reg <= '0;
                pass_reg  <= 1'b1;
            end
            if (ctl.next_range)
            begin
                r_reg     <= r_reg + RCW'(1);
                start_reg <= '0;
            end
            if (ctl.fail_res)
            begin
                cur_r_reg <= '0;
                cur_p_reg <= '0;
            end
            if (ctl.found_wr)
            begin
                if (!p_last)
                begin
                    cur_r_reg <= r_reg;
                    cur_p_reg <= p_found + 32'd1;
                end
                else
                begin
                    cur_r_reg <= r_reg + RCW'(1);
                    cur_p_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_range)
        begin
            offq_reg <= offa;
            offb_reg <= offb_n;
        end
        else if (ctl.next_word)
        begin
            offq_reg <= (offq_reg | BIT_MASK) + OW'(1);
        end
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (ctl.oow_res || ctl.fail_res)
        begin
            res_status_reg <= bnfpa_pkg::STS_FAIL;
            res_page_reg   <= '0;
            res_used_reg   <= 1'b0;
        end
        else if (ctl.mark_wr)
        begin
            res_status_reg <= bnfpa_pkg::STS_OK;
            res_page_reg   <= '0;
            res_used_reg   <= 1'b0;
        end
        else if (ctl.test_res)
        begin
            res_status_reg <= bnfpa_pkg::STS_OK;
            res_page_reg   <= '0;
            res_used_reg   <= rdata_reg[offp[5:0]];
        end
        else if (ctl.app_do)
        begin
            res_status_reg <= app_ok ? bnfpa_pkg::STS_OK : bnfpa_pkg::STS_REJECT;
            res_page_reg   <= '0;
            res_used_reg   <= 1'b0;
        end
        else if (ctl.found_wr)
        begin
            res_status_reg <= bnfpa_pkg::STS_OK;
            res_page_reg   <= p_found;
            res_used_reg   <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            m_tdata_reg <= {7'b0, res_used_reg, res_page_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Status to controller
    assign sts.cmd       = cmd_reg;
    assign sts.clr_done  = (clr_reg == LAST_WORD);
    assign sts.in_win    = in_win;
    assign sts.r_end     = (r_reg >= count_reg);
    assign sts.pass2     = pass_reg;
    assign sts.rng_empty = rng_empty;
    assign sts.found     = found;
    assign sts.last_word = last_word;
    assign sts.out_busy  = m_tvalid_reg & ~m_tready;

endmodule

`default_nettype wire
